[hw/rtl/smfr_pkg.sv]
// ----------------------------------------------------------------------------
// smfr_pkg
// Shared types, constants and helper functions of the frame reassembler.
// ----------------------------------------------------------------------------
package smfr_pkg;

    localparam int STORE_DEPTH = 22;
    localparam int ADDR_W      = 5;
    localparam int SUM_SPAN    = 20;
    localparam int SUM_W       = 13;

    localparam logic [SUM_W-1:0] MARKER_SUM = 13'd266;

    localparam logic [1:0] KIND_PREFIX  = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;
    localparam logic [1:0] KIND_PARAM   = 2'd3;

    localparam logic [7:0] LEN_CODE_PREFIX  = 8'h0C;
    localparam logic [7:0] LEN_CODE_STATUS  = 8'h08;
    localparam logic [7:0] LEN_CODE_CONTROL = 8'h01;

    localparam logic [31:0] MARKER_WORD = 32'h534F4820;

    typedef enum logic [1:0] {
        S_HUNT,
        S_COLLECT,
        S_READ,
        S_LOAD
    } state_t;

    function automatic logic [ADDR_W-1:0] kind_len(input logic [1:0] kind);
        logic [ADDR_W-1:0] len;
        unique case (kind)
            KIND_PREFIX:  len = 5'd12;
            KIND_STATUS:  len = 5'd22;
            KIND_CONTROL: len = 5'd15;
            default:      len = 5'd14;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] marker_byte(input logic [1:0] pos);
        logic [7:0] value;
        unique case (pos)
            2'd0:    value = MARKER_WORD[31:24];
            2'd1:    value = MARKER_WORD[23:16];
            2'd2:    value = MARKER_WORD[15:8];
            default: value = MARKER_WORD[7:0];
        endcase
        return value;
    endfunction

endpackage

[hw/rtl/smfr_if.sv]
// ----------------------------------------------------------------------------
// smfr_if
// Valid/ready channels for received bytes and for reassembled frame bytes.
// ----------------------------------------------------------------------------
interface smfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface smfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [4:0] byte_index;
    logic [1:0] frame_kind;
    logic       sum_match;
    logic       last;

    modport source (output valid, output out_byte, output byte_index,
                    output frame_kind, output sum_match, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_index,
                    input frame_kind, input sum_match, input last,
                    output ready);
endinterface

[hw/rtl/smfr_store.sv]
// ----------------------------------------------------------------------------
// smfr_store
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smfr_store
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [smfr_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic                        re,
    input  logic [smfr_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [smfr_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sync_marker_frame_reassembler.sv]
// ----------------------------------------------------------------------------
// sync_marker_frame_reassembler
// The first frame byte is valid once the final byte is in and S_LOAD has run.
// Input: 1 byte per cycle while hunting or collecting; each output byte needs
// a store read (S_READ), then an output load (S_LOAD), through one read port.
// Reset clears control state; the frame store is not cleared.
// ----------------------------------------------------------------------------
module sync_marker_frame_reassembler
(
    input  logic              clk,
    input  logic              rst_n,
    smfr_in_if.sink           rx,
    smfr_out_if.source        frame
);

    smfr_pkg::state_t state_reg, state_next;

    logic [31:0]                  window_reg, window_next;
    logic [smfr_pkg::ADDR_W-1:0]  count_reg, count_next;
    logic [smfr_pkg::ADDR_W-1:0]  emit_idx_reg, emit_idx_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [smfr_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [7:0]                   b4_reg, b4_next;
    logic [7:0]                   b20_reg, b20_next;
    logic                         nz_reg, nz_next;
    logic                         ok_reg, ok_next;

    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic [smfr_pkg::ADDR_W-1:0]  out_idx_reg, out_idx_next;
    logic [1:0]                   out_kind_reg, out_kind_next;
    logic                         out_ok_reg, out_ok_next;
    logic                         out_last_reg, out_last_next;

    logic                         in_take;
    logic                         wr_en;
    logic                         rd_en;
    logic [7:0]                   rd_data;
    logic [31:0]                  shifted;
    logic                         zeros;
    logic                         emit_last;

    assign rx.ready = (state_reg == smfr_pkg::S_HUNT) || (state_reg == smfr_pkg::S_COLLECT);
    assign in_take  = rx.valid && rx.ready;
    assign shifted  = {window_reg[23:0], rx.in_byte};
    assign zeros    = !nz_reg && (rx.in_byte == 8'h00);
    assign emit_last = (emit_idx_reg + 5'd1) == smfr_pkg::kind_len(kind_reg);

    smfr_store u_store
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg),
        .wdata (rx.in_byte),
        .re    (rd_en),
        .raddr (emit_idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smfr_pkg::S_HUNT;
            window_reg    <= '0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            kind_reg      <= smfr_pkg::KIND_PREFIX;
            sum_reg       <= '0;
            nz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            kind_reg      <= kind_next;
            sum_reg       <= sum_next;
            nz_reg        <= nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b4_reg       <= b4_next;
        b20_reg      <= b20_next;
        ok_reg       <= ok_next;
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_kind_reg <= out_kind_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        kind_next      = kind_reg;
        sum_next       = sum_reg;
        b4_next        = b4_reg;
        b20_next       = b20_reg;
        nz_next        = nz_reg;
        ok_next        = ok_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_kind_next  = out_kind_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !frame.ready;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            smfr_pkg::S_HUNT:
            begin
                if (in_take)
                begin
                    if (shifted == smfr_pkg::MARKER_WORD)
                    begin
                        // The window is cleared when the marker is found, so hunting restarts empty.
                        window_next = '0;
                        count_next  = 5'd4;
                        kind_next   = smfr_pkg::KIND_PREFIX;
                        sum_next    = smfr_pkg::MARKER_SUM;
                        state_next  = smfr_pkg::S_COLLECT;
                    end
                    else
                    begin
                        window_next = shifted;
                    end
                end
            end

            smfr_pkg::S_COLLECT:
            begin
                if (in_take)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 5'd1;
                    if (count_reg < 5'(smfr_pkg::SUM_SPAN))
                    begin
                        sum_next = sum_reg + {5'd0, rx.in_byte};
                    end
                    if (count_reg == 5'd4)
                    begin
                        b4_next = rx.in_byte;
                    end
                    if (count_reg == 5'd5)
                    begin
                        nz_next = rx.in_byte != 8'h00;
                    end
                    if (count_reg == 5'd6)
                    begin
                        nz_next = nz_reg || (rx.in_byte != 8'h00);
                    end
                    if (count_reg == 5'd20)
                    begin
                        b20_next = rx.in_byte;
                    end
                    if (count_reg == 5'd7)
                    begin
                        priority if (zeros && b4_reg == smfr_pkg::LEN_CODE_PREFIX)
                        begin
                            kind_next = smfr_pkg::KIND_PREFIX;
                        end
                        else if (zeros && b4_reg == smfr_pkg::LEN_CODE_STATUS)
                        begin
                            kind_next = smfr_pkg::KIND_STATUS;
                        end
                        else if (zeros && b4_reg == smfr_pkg::LEN_CODE_CONTROL)
                        begin
                            kind_next = smfr_pkg::KIND_CONTROL;
                        end
                        else
                        begin
                            kind_next = smfr_pkg::KIND_PARAM;
                        end
                    end
                    // The length is known from the ninth byte on, and every
                    // length is at least twelve.
                    if (count_reg >= 5'd8 &&
                        (count_reg + 5'd1) == smfr_pkg::kind_len(kind_reg))
                    begin
                        ok_next = (kind_reg == smfr_pkg::KIND_STATUS) &&
                                  ({3'd0, sum_reg} == {rx.in_byte, b20_reg});
                        emit_idx_next = '0;
                        state_next    = smfr_pkg::S_READ;
                    end
                end
            end

            smfr_pkg::S_READ:
            begin
                // Read only once the output register frees up by the next edge.
                if (!out_valid_reg || frame.ready)
                begin
                    rd_en      = 1'b1;
                    state_next = smfr_pkg::S_LOAD;
                end
            end

            smfr_pkg::S_LOAD:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = (emit_idx_reg < 5'd4) ?
                                 smfr_pkg::marker_byte(emit_idx_reg[1:0]) : rd_data;
                out_idx_next   = emit_idx_reg;
                out_kind_next  = kind_reg;
                out_ok_next    = ok_reg;
                out_last_next  = emit_last;
                if (emit_last)
                begin
                    count_next = '0;
                    state_next = smfr_pkg::S_HUNT;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + 5'd1;
                    state_next    = smfr_pkg::S_READ;
                end
            end

            default:
            begin
                state_next = smfr_pkg::S_HUNT;
            end
        endcase
    end

    assign frame.valid       = out_valid_reg;
    assign frame.out_byte    = out_byte_reg;
    assign frame.byte_index  = out_idx_reg;
    assign frame.frame_kind  = out_kind_reg;
    assign frame.sum_match   = out_ok_reg;
    assign frame.last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smfr_pkg::S_LOAD) |-> !out_valid_reg)
        else $error("output register still busy when store data arrives");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == smfr_pkg::S_LOAD))
        else $error("store read not followed by output load");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smfr_pkg::S_COLLECT) |-> (count_reg < 5'(smfr_pkg::STORE_DEPTH)))
        else $error("write address beyond frame store");

    a_first_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.byte_index == 5'd0) |-> (frame.out_byte == 8'h53))
        else $error("frame does not open with the marker");
`endif

endmodule
